### rtl/dbk_pkg.sv
// Package with constants, types and helper functions of the de Bruijn edge table.
`timescale 1ns / 1ps
package dbk_pkg;

  localparam int K         = 15;
  localparam int MAX_EDGES = 4096;
  localparam int WBITS     = 3 * (K + 1);
  localparam int NBITS     = 3 * K;
  localparam int IDX_W     = $clog2(MAX_EDGES);
  localparam int CNT_W     = $clog2(MAX_EDGES + 1);
  localparam int LEN_W     = 16;

  localparam logic [2:0] SYM_N = 3'd4;
  localparam logic [2:0] SYM_D = 3'd5;
  localparam logic [2:0] SYM_LAST = 3'd5;

  localparam logic [2:0] CMD_BEGIN = 3'd0;
  localparam logic [2:0] CMD_CHAR  = 3'd1;
  localparam logic [2:0] CMD_NEXT  = 3'd2;
  localparam logic [2:0] CMD_PREV  = 3'd3;
  localparam logic [2:0] CMD_INFO  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SELWAIT,
    S_SCAN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_INS,
    OP_NEXT,
    OP_PREV,
    OP_INFO
  } op_t;

  function automatic logic [2:0] encode_byte(input logic [7:0] b);
    logic [2:0] s;
    case (b)
      8'h41:   s = 3'd0;
      8'h43:   s = 3'd1;
      8'h47:   s = 3'd2;
      8'h54:   s = 3'd3;
      8'h24:   s = SYM_D;
      default: s = SYM_N;
    endcase
    return s;
  endfunction

  function automatic logic [WBITS-1:0] all_dollars();
    logic [WBITS-1:0] w;
    for (int p = 0; p < K + 1; p++) begin
      w[3*p +: 3] = SYM_D;
    end
    return w;
  endfunction

  function automatic logic [WBITS-1:0] make_key(input op_t op, input logic [WBITS-1:0] w,
                                                 input logic [2:0] label, input logic [2:0] c,
                                                 input logic phase);
    logic [WBITS-1:0] r;
    case (op)
      OP_NEXT: r = {w[WBITS-4:3], label, c};
      OP_PREV: r = {c, w[WBITS-1:3]};
      OP_INFO: r = phase ? {c, w[WBITS-1:3]} : {w[WBITS-1:3], c};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

### rtl/debruijn_kmer_edge_table_core.sv
// Top level of the de Bruijn edge table: sequencer, edge memory and scan compare unit.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_tvalid/in_tready  | cmd in tuser, sequence and query fields in tdata
//  out_    | output    | out_tvalid/out_tready| result fields in tdata, last result in tlast
//
// Every lookup scans the stored edges one per cycle through the single memory read
// port, so an insert scans until a match or the count, and a query takes up to twelve scans.
// Reset clears the count and sequence state; memory entries at or above the count are never used.
// The block takes no item while it works or while a result waits on a low out_tready.
`timescale 1ns / 1ps
module debruijn_kmer_edge_table_core import dbk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[2:0]
  input  logic [2:0]  in_tuser,
  // symbol_byte[7:0], seq_length[23:8], rooted[24], edge_sel[36:25], label_code[39:37]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], edge_out[13:2], is_new[14], node_symbols[59:15], only_outgoing[60],
  // only_incoming[61], dummy_edge[62], edge_count[75:63]
  output logic [79:0] out_tdata,
  output logic        out_tlast
);

  logic [WBITS-1:0] mem [MAX_EDGES];
  logic [WBITS-1:0] rdata_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [WBITS-1:0] key_r, key_nxt, w_r, w_nxt, win_r, win_nxt;
  logic [CNT_W-1:0] j_r, j_nxt, count_r, count_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] jd_r, jd_nxt, sel_r, sel_nxt;
  logic [2:0]       c_r, c_nxt, label_r, label_nxt, cnt_r, cnt_nxt;
  logic             phase_r, phase_nxt, second_r, second_nxt;
  logic [LEN_W-1:0] left_r, left_nxt, seen_r, seen_nxt;
  logic             pad_r, pad_nxt, act_r, act_nxt;

  logic [1:0]       rs_status_r, rs_status_nxt;
  logic [IDX_W-1:0] rs_edge_r, rs_edge_nxt;
  logic             rs_new_r, rs_new_nxt, rs_oo_r, rs_oo_nxt, rs_oi_r, rs_oi_nxt;
  logic             rs_dm_r, rs_dm_nxt, rs_last_r, rs_last_nxt;
  logic [NBITS-1:0] rs_node_r, rs_node_nxt;

  logic [2:0]       in_cmd, in_label;
  logic [7:0]       in_sym;
  logic [LEN_W-1:0] in_len;
  logic             in_rooted;
  logic [IDX_W-1:0] in_sel;
  logic             hit, accept;
  logic [WBITS-1:0] win1, win2;
  logic [LEN_W-1:0] seen1, left1;
  logic [2:0]       cnt_sum;
  logic             dm;

  assign in_cmd    = in_tuser;
  assign in_sym    = in_tdata[7:0];
  assign in_len    = in_tdata[23:8];
  assign in_rooted = in_tdata[24];
  assign in_sel    = in_tdata[36:25];
  assign in_label  = in_tdata[39:37];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = rs_last_r;
  assign out_tdata  = {4'd0, count_r, rs_dm_r, rs_oi_r, rs_oo_r, rs_node_r, rs_new_r,
                       rs_edge_r, rs_status_r};

  assign hit = pend_r && (rdata_r == key_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= key_r;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    dm = 1'b0;
    for (int p = 0; p < K + 1; p++) begin
      if (rdata_r[3*p +: 3] == SYM_D) begin
        dm = 1'b1;
      end
    end
  end

  assign win1    = {win_r[WBITS-4:0], encode_byte(in_sym)};
  assign win2    = {win1[WBITS-4:0], SYM_D};
  assign seen1   = (seen_r == {LEN_W{1'b1}}) ? seen_r : seen_r + 1'b1;
  assign left1   = (left_r != '0) ? left_r - 1'b1 : left_r;
  assign cnt_sum = cnt_r + {2'd0, hit};

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    key_nxt = key_r;
    w_nxt = w_r;
    win_nxt = win_r;
    j_nxt = j_r;
    count_nxt = count_r;
    pend_nxt = 1'b0;
    jd_nxt = jd_r;
    sel_nxt = sel_r;
    c_nxt = c_r;
    label_nxt = label_r;
    cnt_nxt = cnt_r;
    phase_nxt = phase_r;
    second_nxt = second_r;
    left_nxt = left_r;
    seen_nxt = seen_r;
    pad_nxt = pad_r;
    act_nxt = act_r;
    rs_status_nxt = rs_status_r;
    rs_edge_nxt = rs_edge_r;
    rs_new_nxt = rs_new_r;
    rs_oo_nxt = rs_oo_r;
    rs_oi_nxt = rs_oi_r;
    rs_dm_nxt = rs_dm_r;
    rs_last_nxt = rs_last_r;
    rs_node_nxt = rs_node_r;
    rd_addr = in_sel;
    mem_we = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rs_status_nxt = ST_OK;
          rs_edge_nxt = '0;
          rs_new_nxt = 1'b0;
          rs_oo_nxt = 1'b0;
          rs_oi_nxt = 1'b0;
          rs_dm_nxt = 1'b0;
          rs_node_nxt = '0;
          rs_last_nxt = 1'b1;
          second_nxt = 1'b0;
          j_nxt = '0;
          op_nxt = OP_INS;
          case (in_cmd)
            CMD_BEGIN: begin
              win_nxt = all_dollars();
              seen_nxt = '0;
              if (in_len < LEN_W'(K + 1)) begin
                act_nxt = 1'b0;
                left_nxt = '0;
                pad_nxt = 1'b0;
              end else begin
                act_nxt = 1'b1;
                left_nxt = in_len;
                pad_nxt = !in_rooted;
                if (!in_rooted) begin
                  key_nxt = all_dollars();
                  state_nxt = S_SCAN;
                end
              end
            end
            CMD_CHAR: begin
              if (act_r) begin
                seen_nxt = seen1;
                left_nxt = left1;
                win_nxt = win1;
                if (left1 == '0) begin
                  act_nxt = 1'b0;
                  if (pad_r) begin
                    win_nxt = win2;
                  end
                end
                if (pad_r || seen1 >= LEN_W'(K + 1)) begin
                  key_nxt = win1;
                  second_nxt = pad_r && (left1 == '0);
                  rs_last_nxt = !(pad_r && (left1 == '0));
                  state_nxt = S_SCAN;
                end
              end
            end
            CMD_NEXT, CMD_PREV, CMD_INFO: begin
              sel_nxt = in_sel;
              label_nxt = in_label;
              c_nxt = '0;
              cnt_nxt = '0;
              phase_nxt = 1'b0;
              op_nxt = (in_cmd == CMD_NEXT) ? OP_NEXT : (in_cmd == CMD_PREV) ? OP_PREV : OP_INFO;
              if ({1'b0, in_sel} >= count_r) begin
                rs_status_nxt = ST_RANGE;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_SELWAIT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SELWAIT: begin
        w_nxt = rdata_r;
        key_nxt = make_key(op_r, rdata_r, label_r, 3'd0, 1'b0);
        if (op_r == OP_INFO) begin
          rs_edge_nxt = sel_r;
          rs_node_nxt = rdata_r[WBITS-1:3];
          rs_dm_nxt = dm;
        end
        j_nxt = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rd_addr = j_r[IDX_W-1:0];
        if (!hit && j_r < count_r) begin
          pend_nxt = 1'b1;
          jd_nxt = j_r[IDX_W-1:0];
          j_nxt = j_r + 1'b1;
        end else if (hit || !pend_r) begin
          j_nxt = '0;
          case (op_r)
            OP_INS: begin
              state_nxt = S_OUT;
              if (hit) begin
                rs_edge_nxt = jd_r;
              end else if (count_r >= CNT_W'(MAX_EDGES)) begin
                rs_status_nxt = ST_FULL;
              end else begin
                mem_we = 1'b1;
                rs_edge_nxt = count_r[IDX_W-1:0];
                rs_new_nxt = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_NEXT, OP_PREV: begin
              if (hit) begin
                rs_edge_nxt = jd_r;
                state_nxt = S_OUT;
              end else if (c_r == SYM_LAST) begin
                rs_status_nxt = ST_NOTFOUND;
                state_nxt = S_OUT;
              end else begin
                c_nxt = c_r + 1'b1;
                key_nxt = make_key(op_r, w_r, label_r, c_r + 1'b1, 1'b0);
              end
            end
            default: begin
              if (c_r != SYM_LAST) begin
                cnt_nxt = cnt_sum;
                c_nxt = c_r + 1'b1;
                key_nxt = make_key(op_r, w_r, label_r, c_r + 1'b1, phase_r);
              end else if (!phase_r) begin
                rs_oo_nxt = (cnt_sum == 3'd1);
                cnt_nxt = '0;
                c_nxt = '0;
                phase_nxt = 1'b1;
                key_nxt = make_key(op_r, w_r, label_r, 3'd0, 1'b1);
              end else begin
                rs_oi_nxt = (cnt_sum == 3'd1);
                state_nxt = S_OUT;
              end
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (second_r) begin
            second_nxt = 1'b0;
            key_nxt = win_r;
            op_nxt = OP_INS;
            j_nxt = '0;
            rs_status_nxt = ST_OK;
            rs_edge_nxt = '0;
            rs_new_nxt = 1'b0;
            rs_last_nxt = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      win_r <= all_dollars();
      left_r <= '0;
      seen_r <= '0;
      pad_r <= 1'b0;
      act_r <= 1'b0;
      pend_r <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      win_r <= win_nxt;
      left_r <= left_nxt;
      seen_r <= seen_nxt;
      pad_r <= pad_nxt;
      act_r <= act_nxt;
      pend_r <= pend_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    key_r <= key_nxt;
    w_r <= w_nxt;
    j_r <= j_nxt;
    jd_r <= jd_nxt;
    sel_r <= sel_nxt;
    c_r <= c_nxt;
    label_r <= label_nxt;
    cnt_r <= cnt_nxt;
    phase_r <= phase_nxt;
    rs_status_r <= rs_status_nxt;
    rs_edge_r <= rs_edge_nxt;
    rs_new_r <= rs_new_nxt;
    rs_oo_r <= rs_oo_nxt;
    rs_oi_r <= rs_oi_nxt;
    rs_dm_r <= rs_dm_nxt;
    rs_last_r <= rs_last_nxt;
    rs_node_r <= rs_node_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_EDGES)) else $error("edge count beyond table size");

  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> count_r == $past(count_r) + 1'b1) else $error("write without count step");

  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_SCAN) else $error("compare pending outside scan");

  a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && second_r) |-> !out_tlast) else $error("first of two results marked last");

endmodule

### bench/debruijn_kmer_edge_table_core_test.sv
// Self-checking testbench of the de Bruijn edge table core with its own edge table predictor.
`timescale 1ns / 1ps
module debruijn_kmer_edge_table_core_test;
  import dbk_pkg::*;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  sym;
    logic [15:0] len;
    logic        rooted;
    logic [11:0] sel;
    logic [2:0]  label;
    logic        typed;
    logic [79:0] want;
  } edge_item_t;

  typedef struct {
    logic [79:0] data;
    logic        last;
  } edge_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tlast;

  logic [WBITS-1:0] kmer_table [MAX_EDGES];
  int unsigned      kmer_count;
  logic [WBITS-1:0] win;
  int unsigned      left_chars;
  int unsigned      seen_chars;
  logic             pad_mode;
  logic             seq_on;

  edge_result_t fresh_q[$];
  edge_result_t pending_q[$];
  edge_item_t   rows[$];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_req;
  int unsigned  hold_left;
  int unsigned  errors;

  debruijn_kmer_edge_table_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [79:0] pack_result(logic [1:0] st, logic [11:0] e, logic nw,
                                              logic [44:0] node, logic oo, logic oi,
                                              logic dm, int unsigned cnt);
    logic [12:0] c;
    c = cnt[12:0];
    return {4'b0, c, dm, oi, oo, node, nw, e, st};
  endfunction

  function automatic bit find_kmer(logic [WBITS-1:0] k, output int unsigned at);
    at = 0;
    for (int unsigned j = 0; j < kmer_count; j++) begin
      if (kmer_table[j] == k) begin
        at = j;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] sym_code(logic [7:0] b);
    case (b)
      "A":     return 3'd0;
      "C":     return 3'd1;
      "G":     return 3'd2;
      "T":     return 3'd3;
      "$":     return SYM_D;
      default: return SYM_N;
    endcase
  endfunction

  task automatic add_kmer(logic [WBITS-1:0] k);
    int unsigned at;
    edge_result_t r;
    r.last = 1'b0;
    if (find_kmer(k, at)) begin
      r.data = pack_result(ST_OK, at[11:0], 1'b0, '0, 1'b0, 1'b0, 1'b0, kmer_count);
    end else if (kmer_count >= MAX_EDGES) begin
      r.data = pack_result(ST_FULL, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, kmer_count);
    end else begin
      at = kmer_count;
      kmer_table[at] = k;
      kmer_count++;
      r.data = pack_result(ST_OK, at[11:0], 1'b1, '0, 1'b0, 1'b0, 1'b0, kmer_count);
    end
    fresh_q = {fresh_q, r};
  endtask

  task automatic predict_edges(edge_item_t it);
    logic [WBITS-1:0] w;
    logic [WBITS-1:0] cand;
    int unsigned at;
    int unsigned n_out;
    int unsigned n_in;
    logic dm;
    bit hit;
    edge_result_t r;
    fresh_q.delete();
    r.last = 1'b0;
    if (it.cmd == CMD_BEGIN) begin
      win = all_dollars();
      seen_chars = 0;
      if (it.len < K + 1) begin
        seq_on = 1'b0;
        left_chars = 0;
        pad_mode = 1'b0;
      end else begin
        seq_on = 1'b1;
        left_chars = it.len;
        pad_mode = !it.rooted;
        if (pad_mode) add_kmer(win);
      end
    end else if (it.cmd == CMD_CHAR) begin
      if (seq_on) begin
        win = {win[WBITS-4:0], sym_code(it.sym)};
        if (seen_chars < 16'hFFFF) seen_chars++;
        if (left_chars > 0) left_chars--;
        if (pad_mode || seen_chars >= K + 1) add_kmer(win);
        if (left_chars == 0) begin
          seq_on = 1'b0;
          if (pad_mode) begin
            win = {win[WBITS-4:0], SYM_D};
            add_kmer(win);
          end
        end
      end
    end else if (it.cmd == CMD_NEXT || it.cmd == CMD_PREV || it.cmd == CMD_INFO) begin
      if (it.sel >= kmer_count) begin
        r.data = pack_result(ST_RANGE, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, kmer_count);
      end else begin
        w = kmer_table[it.sel];
        if (it.cmd == CMD_INFO) begin
          dm = 1'b0;
          n_out = 0;
          n_in = 0;
          for (int p = 0; p < K + 1; p++) if (w[3*p +: 3] == SYM_D) dm = 1'b1;
          for (int c = 0; c < 6; c++) begin
            if (find_kmer({w[WBITS-1:3], 3'(c)}, at)) n_out++;
            if (find_kmer({3'(c), w[WBITS-1:3]}, at)) n_in++;
          end
          r.data = pack_result(ST_OK, it.sel, 1'b0, w[WBITS-1:3], n_out == 1, n_in == 1, dm,
                               kmer_count);
        end else begin
          hit = 1'b0;
          at = 0;
          for (int c = 0; c < 6 && !hit; c++) begin
            if (it.cmd == CMD_NEXT) cand = {w[WBITS-4:3], it.label, 3'(c)};
            else cand = {3'(c), w[WBITS-1:3]};
            hit = find_kmer(cand, at);
          end
          if (hit) r.data = pack_result(ST_OK, at[11:0], 1'b0, '0, 1'b0, 1'b0, 1'b0,
                                        kmer_count);
          else r.data = pack_result(ST_NOTFOUND, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, kmer_count);
        end
      end
      fresh_q = {fresh_q, r};
    end
    if (fresh_q.size() > 0) fresh_q[fresh_q.size()-1].last = 1'b1;
  endtask

  task automatic send_item(edge_item_t it);
    edge_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.cmd;
    in_tdata <= {it.label, it.sel, it.rooted, it.len, it.sym};
    do @(posedge clk); while (!in_tready);
    predict_edges(it);
    if (it.typed) begin
      r.data = it.want;
      r.last = 1'b1;
      pending_q = {pending_q, r};
    end else begin
      foreach (fresh_q[i]) pending_q = {pending_q, fresh_q[i]};
    end
  endtask

  task automatic add_row(edge_item_t it);
    rows = {rows, it};
  endtask

  function automatic edge_item_t mk(logic [2:0] cmd, logic [7:0] sym, logic [15:0] len,
                                    logic rooted, logic [11:0] sel, logic [2:0] label);
    edge_item_t it;
    it.cmd = cmd;
    it.sym = sym;
    it.len = len;
    it.rooted = rooted;
    it.sel = sel;
    it.label = label;
    it.typed = 1'b0;
    it.want = '0;
    return it;
  endfunction

  function automatic edge_item_t mk_typed(edge_item_t it, logic [79:0] want);
    it.typed = 1'b1;
    it.want = want;
    return it;
  endfunction

  function automatic logic [7:0] rand_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) begin
      case ($urandom_range(3))
        0: return "A";
        1: return "C";
        2: return "G";
        default: return "T";
      endcase
    end
    if (r < 90) return "N";
    if (r < 94) return "$";
    return 8'($urandom());
  endfunction

  task automatic send_random(int unsigned n_items);
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    int unsigned chars;
    logic [7:0] motif [4];
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 50) begin
        r = $urandom_range(99);
        if (r < 80) len = $urandom_range(K + 1, K + 6);
        else if (r < 92) len = $urandom_range(K);
        else len = $urandom_range(16'hFFFF);
        send_item(mk(CMD_BEGIN, 8'($urandom()), 16'(len), 1'($urandom()), 12'($urandom()),
                     3'($urandom())));
        sent++;
        chars = (len > K + 8) ? $urandom_range(K + 1, K + 8) : len;
        if ($urandom_range(9) == 0) chars = $urandom_range(chars);
        for (int m = 0; m < 4; m++) motif[m] = rand_char();
        for (int c = 0; c < chars; c++) begin
          if (kmer_count > 250 || $urandom_range(2) == 0)
            send_item(mk(CMD_CHAR, motif[c % 4], 16'($urandom()), 1'($urandom()),
                         12'($urandom()), 3'($urandom())));
          else
            send_item(mk(CMD_CHAR, rand_char(), 16'($urandom()), 1'($urandom()),
                         12'($urandom()), 3'($urandom())));
          sent++;
        end
      end else if (r < 95) begin
        if ($urandom_range(9) == 0 || kmer_count == 0)
          send_item(mk(3'($urandom_range(CMD_NEXT, CMD_INFO)), 8'($urandom()),
                       16'($urandom()), 1'($urandom()), 12'($urandom()), 3'($urandom())));
        else
          send_item(mk(3'($urandom_range(CMD_NEXT, CMD_INFO)), 8'($urandom()),
                       16'($urandom()), 1'($urandom()), 12'($urandom_range(kmer_count - 1)),
                       3'($urandom())));
        sent++;
      end else begin
        send_item(mk(3'($urandom_range(5, 7)), 8'($urandom()), 16'($urandom()),
                     1'($urandom()), 12'($urandom()), 3'($urandom())));
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    edge_result_t e;
    if (out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h last %b", $time, out_tdata, out_tlast);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_tdata !== e.data || out_tlast !== e.last) begin
          $display("%0t: expected %h last %b, actual %h last %b", $time, e.data, e.last,
                   out_tdata, out_tlast);
          errors++;
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #1_000_000_000;
    $display("debruijn_kmer_edge_table_core test failed");
    $finish;
  end

  initial begin
    errors = 0;
    hold_req = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    kmer_count = 0;
    win = all_dollars();
    left_chars = 0;
    seen_chars = 0;
    pad_mode = 1'b0;
    seq_on = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mk_typed(mk(CMD_NEXT, 0, 0, 0, 0, 0),
                     pack_result(ST_RANGE, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0)));
    add_row(mk_typed(mk(CMD_PREV, 0, 0, 0, 12'hFFF, 0),
                     pack_result(ST_RANGE, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0)));
    add_row(mk_typed(mk(CMD_INFO, 0, 0, 0, 0, 0),
                     pack_result(ST_RANGE, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, 0)));
    add_row(mk(CMD_CHAR, "A", 0, 0, 0, 0));
    add_row(mk(3'd5, 8'hFF, 16'hFFFF, 1, 12'hFFF, 3'd7));
    add_row(mk(3'd7, 0, 0, 0, 0, 0));
    add_row(mk(CMD_BEGIN, 0, 16'd15, 0, 0, 0));
    add_row(mk(CMD_CHAR, "C", 0, 0, 0, 0));
    add_row(mk_typed(mk(CMD_BEGIN, 0, 16'd16, 0, 0, 0),
                     pack_result(ST_OK, 12'd0, 1'b1, '0, 1'b0, 1'b0, 1'b0, 1)));
    for (int i = 0; i < 16; i++) begin
      case (i % 8)
        0: add_row(mk(CMD_CHAR, "A", 0, 0, 0, 0));
        1: add_row(mk(CMD_CHAR, "C", 0, 0, 0, 0));
        2: add_row(mk(CMD_CHAR, "G", 0, 0, 0, 0));
        3: add_row(mk(CMD_CHAR, "T", 0, 0, 0, 0));
        4: add_row(mk(CMD_CHAR, "N", 0, 0, 0, 0));
        5: add_row(mk(CMD_CHAR, "$", 0, 0, 0, 0));
        6: add_row(mk(CMD_CHAR, 8'hFF, 0, 0, 0, 0));
        default: add_row(mk(CMD_CHAR, 8'h00, 0, 0, 0, 0));
      endcase
    end
    add_row(mk(CMD_NEXT, 0, 0, 0, 12'd0, 3'd0));
    add_row(mk(CMD_NEXT, 0, 0, 0, 12'd3, 3'd6));
    add_row(mk(CMD_PREV, 0, 0, 0, 12'd5, 0));
    add_row(mk(CMD_INFO, 0, 0, 0, 12'd0, 0));
    add_row(mk(CMD_INFO, 0, 0, 0, 12'd17, 0));
    add_row(mk(CMD_BEGIN, 0, 16'hFFFF, 1, 0, 0));
    foreach (rows[i]) send_item(rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 0;  recv_stall_pct = 88; hold_req = 2000; end
        2: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      send_random(160);
    end
    in_tvalid <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk);
    repeat (60000) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("debruijn_kmer_edge_table_core test passed");
    end else begin
      $display("debruijn_kmer_edge_table_core test failed");
    end
    $finish;
  end

endmodule
